### hw/rtl/tct_pkg.sv
// ----------------------------------------------------------------------------
// tct_pkg
// Types, codes and constants shared by the timed callback table files.
// ----------------------------------------------------------------------------
package tct_pkg;

    localparam int SLOTS_DEF   = 64;
    localparam int SLOT_W      = 6;
    localparam int PERIOD_W    = 10;
    localparam int AMOUNT_W    = 16;
    localparam int ID_W        = 8;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd55;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_ROUND  = 2'd3;

    localparam logic [2:0] MODE_PLAIN       = 3'd0;
    localparam logic [2:0] MODE_LIMITED     = 3'd1;
    localparam logic [2:0] MODE_NEXT_TICK   = 3'd2;
    localparam logic [2:0] MODE_WHILE       = 3'd3;
    localparam logic [2:0] MODE_AFTER       = 3'd4;
    localparam logic [2:0] MODE_WHILE_AFTER = 3'd5;

    localparam logic [1:0] ST_ADDED   = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NOT_ADD = 2'd3;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic [2:0]                 mode;
        logic signed [AMOUNT_W-1:0] amount;
        logic [ID_W-1:0]            main_id;
        logic [ID_W-1:0]            sub_id;
        logic [SLOT_W-1:0]          target_slot;
    } t_in_word;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              fire_main;
        logic              fire_sub;
        logic [ID_W-1:0]   out_main;
        logic [ID_W-1:0]   out_sub;
        logic [1:0]        add_status;
        logic              last;
    } t_out_word;

    typedef struct packed {
        logic [2:0]                 mode;
        logic signed [AMOUNT_W-1:0] timer;
        logic [ID_W-1:0]            main_id;
        logic [ID_W-1:0]            sub_id;
    } t_entry;

    typedef struct packed {
        logic                we;
        logic [SLOT_W-1:0]   waddr;
        t_entry              wdata;
        logic [SLOT_W-1:0]   raddr;
    } t_ram_req;

endpackage

### hw/rtl/timed_callback_table_core.sv
// ----------------------------------------------------------------------------
// timed_callback_table_core
// Table of timed callback entries with add, remove, tick and round commands.
// ----------------------------------------------------------------------------
//  channel  ports                      handshake
//  command  i_start, i_word, o_busy    taken when i_start && !o_busy
//  result   o_strobe, o_word           one cycle per word, no stall
//  config   i_cfg_we, i_cfg_wdata      written when i_cfg_we
//
//  remove completes in S_IDLE; add, tick and round walk the slots through
//  one ram read port, each slot read in S_READ and judged in S_EVAL; tick
//  and round share one subtractor, and an add stops at its first result.
//  a result word waits for the next one so the final one can carry last.
//  reset clears the enable bits and loads the tick period of 55; entry data
//  needs none.
//  results cannot be stalled.
// ----------------------------------------------------------------------------
module timed_callback_table_core #(
    parameter int SLOTS = tct_pkg::SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  tct_pkg::t_in_word              i_word,
    output logic                           o_busy,
    input  logic                           i_cfg_we,
    input  logic [tct_pkg::PERIOD_W-1:0]   i_cfg_wdata,
    output logic                           o_strobe,
    output tct_pkg::t_out_word             o_word
);
    import tct_pkg::*;

    localparam int IW = $clog2(SLOTS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EVAL = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [SLOTS-1:0]    r_en, n_en;
    logic [PERIOD_W-1:0] r_period;
    logic [IW-1:0]       r_idx, n_idx;
    t_in_word            r_cmd, n_cmd;
    logic                r_strobe, n_strobe;
    t_out_word           r_out, n_out;
    logic                r_pend_vld, n_pend_vld;
    t_out_word           r_pend, n_pend;

    t_ram_req            ram_req;
    t_entry              rdata;
    logic                accept;
    logic                last_slot;
    logic signed [AMOUNT_W+1:0] diff;
    logic                done;
    logic                fm, fs, timed;
    t_out_word           fire_w;

    tct_slot_ram #(.SLOTS(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (rdata)
    );

    assign accept    = i_start && (r_state == S_IDLE);
    assign last_slot = (r_idx == IW'(SLOTS - 1));

    // shared subtractor: tick period on a tick, one on a round
    always_comb begin
        if (r_cmd.cmd == CMD_TICK) begin
            diff = (AMOUNT_W+2)'(rdata.timer) - $signed({8'd0, r_period});
        end else begin
            diff = (AMOUNT_W+2)'(rdata.timer) - (AMOUNT_W+2)'(1);
        end
        done = (diff <= 0);
    end

    always_comb begin
        fm    = 1'b0;
        fs    = 1'b0;
        timed = 1'b0;
        if (r_cmd.cmd == CMD_TICK) begin
            case (rdata.mode)
                MODE_NEXT_TICK:   fm = 1'b1;
                MODE_WHILE: begin
                    fm    = 1'b1;
                    timed = 1'b1;
                end
                MODE_AFTER: begin
                    fm    = done;
                    timed = 1'b1;
                end
                MODE_WHILE_AFTER: begin
                    fm    = 1'b1;
                    fs    = done;
                    timed = 1'b1;
                end
                default: begin
                    fm = 1'b0;
                end
            endcase
        end else begin
            case (rdata.mode)
                MODE_PLAIN:   fm = 1'b1;
                MODE_LIMITED: begin
                    fm    = 1'b1;
                    timed = 1'b1;
                end
                default: begin
                    fm = 1'b0;
                end
            endcase
        end
        fire_w.slot       = SLOT_W'(r_idx);
        fire_w.fire_main  = fm;
        fire_w.fire_sub   = fs;
        fire_w.out_main   = rdata.main_id;
        fire_w.out_sub    = rdata.sub_id;
        fire_w.add_status = ST_NOT_ADD;
        fire_w.last       = 1'b0;
    end

    always_comb begin
        n_state    = r_state;
        n_en       = r_en;
        n_idx      = r_idx;
        n_cmd      = r_cmd;
        n_strobe   = 1'b0;
        n_out      = r_out;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;

        ram_req.we            = 1'b0;
        ram_req.waddr         = SLOT_W'(r_idx);
        ram_req.wdata         = rdata;
        ram_req.wdata.timer   = diff[AMOUNT_W-1:0];
        ram_req.raddr         = SLOT_W'(r_idx);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd      = i_word;
                    n_idx      = '0;
                    n_pend_vld = 1'b0;
                    if (i_word.cmd == CMD_REMOVE) begin
                        if (32'(i_word.target_slot) < SLOTS) begin
                            n_en[i_word.target_slot[IW-1:0]] = 1'b0;
                        end
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_cmd.cmd == CMD_ADD) begin
                    n_out.fire_main = 1'b0;
                    n_out.fire_sub  = 1'b0;
                    n_out.out_main  = '0;
                    n_out.out_sub   = '0;
                    n_out.last      = 1'b1;
                    n_out.slot      = SLOT_W'(r_idx);
                    if (!r_en[r_idx]) begin
                        ram_req.we            = 1'b1;
                        ram_req.wdata.mode    = (r_cmd.mode > MODE_WHILE_AFTER) ?
                                                MODE_PLAIN : r_cmd.mode;
                        ram_req.wdata.timer   = r_cmd.amount;
                        ram_req.wdata.main_id = r_cmd.main_id;
                        ram_req.wdata.sub_id  = r_cmd.sub_id;
                        n_en[r_idx]      = 1'b1;
                        n_out.add_status = ST_ADDED;
                        n_strobe         = 1'b1;
                        n_state          = S_IDLE;
                    end else if (rdata.main_id == r_cmd.main_id) begin
                        n_out.add_status = ST_DUP;
                        n_strobe         = 1'b1;
                        n_state          = S_IDLE;
                    end else if (last_slot) begin
                        n_out.add_status = ST_FULL;
                        n_out.slot       = '0;
                        n_strobe         = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_READ;
                    end
                end else begin
                    if (r_en[r_idx] && (fm || timed)) begin
                        if (timed && done) begin
                            n_en[r_idx] = 1'b0;
                        end else if (timed) begin
                            ram_req.we = 1'b1;
                        end else begin
                            n_en[r_idx] = 1'b0;
                        end
                        if (fm || fs) begin
                            if (r_pend_vld) begin
                                n_out    = r_pend;
                                n_strobe = 1'b1;
                            end
                            n_pend     = fire_w;
                            n_pend_vld = 1'b1;
                        end
                    end
                    if (r_en[r_idx] && !timed && fm && (r_cmd.cmd == CMD_ROUND)) begin
                        n_en[r_idx] = 1'b1;
                    end
                    if (last_slot) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_DONE: begin
                if (r_pend_vld) begin
                    n_out      = r_pend;
                    n_out.last = 1'b1;
                    n_strobe   = 1'b1;
                end
                n_pend_vld = 1'b0;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_en       <= '0;
            r_period   <= PERIOD_RST;
            r_idx      <= '0;
            r_strobe   <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_en       <= n_en;
            r_idx      <= n_idx;
            r_strobe   <= n_strobe;
            r_pend_vld <= n_pend_vld;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_word   = r_out;

endmodule

### hw/rtl/tct_slot_ram.sv
// ----------------------------------------------------------------------------
// tct_slot_ram
// Entry storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tct_slot_ram #(
    parameter int SLOTS = tct_pkg::SLOTS_DEF
) (
    input  logic              i_clk,
    input  tct_pkg::t_ram_req i_req,
    output tct_pkg::t_entry   o_rdata
);
    import tct_pkg::*;

    localparam int IW = $clog2(SLOTS);

    t_entry r_mem [SLOTS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[IW-1:0]] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr[IW-1:0]];
    end

    assign o_rdata = r_rdata;

endmodule

### tb/sv/timed_callback_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_callback_table_core_tb
// Self-checking bench for the timed callback table. A driver feeds command
// words from a backlog, a monitor compares every result word against a
// cycle-free table predictor. Directed corner cases run at the reset tick
// period, then randomized add, tick, round and remove sequences run under
// several tick periods, including zero and full scale, and one full-table pass.
// ----------------------------------------------------------------------------
module timed_callback_table_core_tb;
    import tct_pkg::*;

    localparam int SLOTS = SLOTS_DEF;
    localparam int LAT   = 2 * SLOTS + 8;
    localparam int LIMIT = 400000;
    localparam int PHASE_ITEMS = 49;

    typedef struct packed {
        t_in_word   word;
        logic [2:0] gap;
        logic       drain;
    } t_pending;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_start = 1'b0;
    t_in_word            i_word = '0;
    logic                i_cfg_we = 1'b0;
    logic [PERIOD_W-1:0] i_cfg_wdata = '0;
    logic                o_busy;
    logic                o_strobe;
    t_out_word           o_word;

    timed_callback_table_core #(.SLOTS(SLOTS)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_word      (i_word),
        .o_busy      (o_busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_word      (o_word)
    );

    // predictor state
    logic                tbl_en   [SLOTS];
    logic [2:0]          tbl_mode [SLOTS];
    int                  tbl_timer[SLOTS];
    logic [ID_W-1:0]     tbl_main [SLOTS];
    logic [ID_W-1:0]     tbl_sub  [SLOTS];
    logic [PERIOD_W-1:0] tick_per;

    t_pending  cmd_backlog[$];
    t_out_word due_words[$];

    int  n_queued = 0;
    int  n_sent = 0;
    int  n_err = 0;
    int  n_words = 0;
    int  n_added = 0;
    int  n_dup = 0;
    int  n_full = 0;
    int  n_sub = 0;
    int  n_periods = 0;
    int  cycles = 0;
    bit  no_idle = 0;

    logic      start_nxt;
    int        idle_cyc;
    t_pending  nxt;
    t_out_word want;
    string     bad;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due", cycles, due_words.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_out_word fired(input int slot, input logic fm, input logic fs);
        t_out_word r;
        r = '0;
        r.slot       = slot[SLOT_W-1:0];
        r.fire_main  = fm;
        r.fire_sub   = fs;
        r.out_main   = tbl_main[slot];
        r.out_sub    = tbl_sub[slot];
        r.add_status = ST_NOT_ADD;
        return r;
    endfunction

    task automatic table_step(input t_in_word w);
        t_out_word batch[$];
        t_out_word r;
        int        i;
        int        t;
        logic      fm;
        logic      fs;
        logic      done;
        logic      found;
        case (w.cmd)
            CMD_ADD: begin
                r = '0;
                r.add_status = ST_FULL;
                found = 1'b0;
                for (i = 0; i < SLOTS; i++) begin
                    if (!found && tbl_en[i]) begin
                        if (tbl_main[i] == w.main_id) begin
                            r.add_status = ST_DUP;
                            r.slot = i[SLOT_W-1:0];
                            found = 1'b1;
                        end
                    end else if (!found) begin
                        tbl_en[i]    = 1'b1;
                        tbl_mode[i]  = (w.mode > MODE_WHILE_AFTER) ? MODE_PLAIN : w.mode;
                        tbl_timer[i] = int'(w.amount);
                        tbl_main[i]  = w.main_id;
                        tbl_sub[i]   = w.sub_id;
                        r.add_status = ST_ADDED;
                        r.slot = i[SLOT_W-1:0];
                        found = 1'b1;
                    end
                end
                batch.push_back(r);
            end
            CMD_REMOVE: begin
                if (int'(w.target_slot) < SLOTS) tbl_en[w.target_slot] = 1'b0;
            end
            CMD_TICK: begin
                for (i = 0; i < SLOTS; i++) begin
                    if (tbl_en[i] && tbl_mode[i] >= MODE_NEXT_TICK) begin
                        fm = 1'b0;
                        fs = 1'b0;
                        if (tbl_mode[i] == MODE_NEXT_TICK) begin
                            fm = 1'b1;
                            tbl_en[i] = 1'b0;
                        end else begin
                            // full precision, so the timer never wraps
                            t = tbl_timer[i] - int'(tick_per);
                            done = (t <= 0);
                            if (!done) tbl_timer[i] = t;
                            if (tbl_mode[i] == MODE_WHILE) begin
                                fm = 1'b1;
                            end else if (tbl_mode[i] == MODE_AFTER) begin
                                fm = done;
                            end else begin
                                fm = 1'b1;
                                fs = done;
                            end
                            if (done) tbl_en[i] = 1'b0;
                        end
                        if (fm || fs) batch.push_back(fired(i, fm, fs));
                    end
                end
            end
            default: begin
                for (i = 0; i < SLOTS; i++) begin
                    if (tbl_en[i] && tbl_mode[i] <= MODE_LIMITED) begin
                        batch.push_back(fired(i, 1'b1, 1'b0));
                        if (tbl_mode[i] == MODE_LIMITED) begin
                            t = tbl_timer[i] - 1;
                            if (t <= 0) tbl_en[i] = 1'b0;
                            else tbl_timer[i] = t;
                        end
                    end
                end
            end
        endcase
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        foreach (batch[k]) due_words.push_back(batch[k]);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            idle_cyc = 0;
        end else begin
            start_nxt = i_start;
            if (i_start && !o_busy) begin
                table_step(i_word);
                n_sent++;
                start_nxt = 1'b0;
                idle_cyc = 0;
            end else if (!i_start) begin
                idle_cyc++;
            end
            if (!start_nxt && cmd_backlog.size() > 0) begin
                if (idle_cyc >= int'(cmd_backlog[0].gap) &&
                    !(cmd_backlog[0].drain && due_words.size() > 0)) begin
                    nxt = cmd_backlog.pop_front();
                    i_word <= nxt.word;
                    start_nxt = 1'b1;
                end
            end
            i_start <= start_nxt;
        end
    end

    function automatic string word_str(input t_out_word w);
        return $sformatf("slot=%0d fm=%0b fs=%0b main=%0d sub=%0d st=%0d last=%0b",
                         w.slot, w.fire_main, w.fire_sub, w.out_main, w.out_sub,
                         w.add_status, w.last);
    endfunction

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            n_words++;
            if (o_word.add_status == ST_ADDED) n_added++;
            if (o_word.add_status == ST_DUP) n_dup++;
            if (o_word.add_status == ST_FULL) n_full++;
            if (o_word.fire_sub) n_sub++;
            if (due_words.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result word: %s", word_str(o_word));
            end else begin
                want = due_words.pop_front();
                bad = "";
                if (o_word.slot !== want.slot) bad = {bad, " slot"};
                if (o_word.fire_main !== want.fire_main) bad = {bad, " fire_main"};
                if (o_word.fire_sub !== want.fire_sub) bad = {bad, " fire_sub"};
                if (o_word.out_main !== want.out_main) bad = {bad, " out_main"};
                if (o_word.out_sub !== want.out_sub) bad = {bad, " out_sub"};
                if (o_word.add_status !== want.add_status) bad = {bad, " add_status"};
                if (o_word.last !== want.last) bad = {bad, " last"};
                if (bad != "") begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("mismatch on%s", bad);
                        $display("  expected %s", word_str(want));
                        $display("  actual   %s", word_str(o_word));
                    end
                end
            end
        end
    end

    // stimulus
    function automatic t_in_word noise_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(t_in_word)-1:0];
    endfunction

    function automatic t_in_word add_word(input logic [2:0] m, input logic [15:0] amt,
                                          input logic [7:0] mid, input logic [7:0] sid);
        t_in_word w;
        w = noise_word();
        w.cmd     = CMD_ADD;
        w.mode    = m;
        w.amount  = amt;
        w.main_id = mid;
        w.sub_id  = sid;
        return w;
    endfunction

    function automatic t_in_word op_word(input logic [1:0] c, input logic [5:0] tgt);
        t_in_word w;
        w = noise_word();
        w.cmd = c;
        w.target_slot = tgt;
        return w;
    endfunction

    function automatic logic [15:0] rand_amount(input logic [2:0] m);
        int k;
        int v;
        k = $urandom_range(0, 9);
        if (k < 6) begin
            if (m == MODE_LIMITED) v = $urandom_range(0, 6) - 1;
            else v = $urandom_range(0, 4) * tick_per + $urandom_range(0, tick_per);
        end else if (k < 8) begin
            v = $urandom;
        end else if (k == 8) begin
            v = $urandom_range(0, 1) ? 32767 : -32768;
        end else begin
            v = int'($urandom_range(0, 2)) - 1;
        end
        return v[15:0];
    endfunction

    function automatic int pick_live();
        int live[$];
        int i;
        for (i = 0; i < SLOTS; i++) if (tbl_en[i]) live.push_back(i);
        if (live.size() == 0) return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    task automatic queue_word(input t_in_word w, input logic drain);
        t_pending p;
        p.word  = w;
        p.gap   = no_idle ? 3'd0 : 3'($urandom_range(0, 4));
        p.drain = drain;
        cmd_backlog.push_back(p);
        n_queued++;
    endtask

    task automatic sync_sender();
        while (n_sent < n_queued) @(posedge i_clk);
    endtask

    task automatic set_period(input logic [PERIOD_W-1:0] p);
        sync_sender();
        while (due_words.size() > 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= p;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tick_per = p;
        n_periods++;
    endtask

    task automatic fill_table();
        logic used[256];
        int   i;
        int   free_n;
        int   id;
        int   first_id;
        logic [2:0] m;
        free_n = 0;
        for (i = 0; i < 256; i++) used[i] = 1'b0;
        for (i = 0; i < SLOTS; i++) begin
            if (tbl_en[i]) used[tbl_main[i]] = 1'b1;
            else free_n++;
        end
        id = $urandom_range(0, 255);
        first_id = -1;
        // one more fresh id than free slots, so the last add finds the table full
        for (i = 0; i < free_n + 1; i++) begin
            while (used[id]) id = (id + 1) % 256;
            used[id] = 1'b1;
            if (first_id < 0) first_id = id;
            m = 3'($urandom_range(0, 5));
            queue_word(add_word(m, rand_amount(m), id[7:0], 8'($urandom_range(0, 255))),
                       1'b0);
        end
        queue_word(add_word(MODE_PLAIN, 16'd1, first_id[7:0], 8'd0), 1'b0);
        queue_word(op_word(CMD_ROUND, 6'd0), 1'b0);
        queue_word(op_word(CMD_TICK, 6'd0), 1'b0);
    endtask

    task automatic random_sequence();
        int   n;
        int   k;
        int   s;
        int   pick;
        logic [2:0] m;
        logic [7:0] mid;
        sync_sender();
        no_idle = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 19);
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
            if (pick < 7) begin
                m = 3'($urandom_range(0, 7));
                s = pick_live();
                if (s >= 0 && $urandom_range(0, 2) == 0) mid = tbl_main[s];
                else if ($urandom_range(0, 1) == 0) mid = 8'($urandom_range(0, 15));
                else mid = 8'($urandom_range(0, 255));
                queue_word(add_word(m, rand_amount(m), mid, 8'($urandom_range(0, 255))),
                           1'b0);
            end else if (pick < 11) begin
                if (k < 5)
                    queue_word(op_word(CMD_TICK, 6'($urandom_range(0, 63))),
                               $urandom_range(0, 9) == 0);
            end else if (pick < 14) begin
                if (k < 4) queue_word(op_word(CMD_ROUND, 6'($urandom_range(0, 63))), 1'b0);
            end else if (pick < 17) begin
                s = pick_live();
                if (k < 3) begin
                    if (s >= 0 && $urandom_range(0, 9) < 7)
                        queue_word(op_word(CMD_REMOVE, s[5:0]), 1'b0);
                    else
                        queue_word(op_word(CMD_REMOVE, 6'($urandom_range(0, 63))), 1'b0);
                end
            end else begin
                queue_word(noise_word(), 1'b0);
            end
        end
    endtask

    int   ph;
    int   dir_n;
    int   waited;
    logic [PERIOD_W-1:0] periods[5];

    initial begin
        tick_per = PERIOD_RST;
        for (int i = 0; i < SLOTS; i++) tbl_en[i] = 1'b0;
        periods = '{10'd1, 10'd1000, 10'd0, 10'd1023, 10'd0};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners at the reset tick period
        queue_word(op_word(CMD_ROUND, 6'd0), 1'b0);
        queue_word(op_word(CMD_TICK, 6'd63), 1'b0);
        queue_word(add_word(MODE_PLAIN, 16'd0, 8'd0, 8'd255), 1'b0);
        queue_word(add_word(MODE_LIMITED, 16'd2, 8'd255, 8'd0), 1'b0);
        queue_word(add_word(MODE_PLAIN, 16'd5, 8'd0, 8'd1), 1'b0);
        queue_word(add_word(MODE_NEXT_TICK, 16'd0, 8'd10, 8'd11), 1'b0);
        queue_word(add_word(MODE_WHILE, 16'd100, 8'd12, 8'd13), 1'b0);
        queue_word(add_word(MODE_AFTER, 16'd56, 8'd14, 8'd15), 1'b0);
        queue_word(add_word(MODE_WHILE_AFTER, 16'd55, 8'd16, 8'd17), 1'b0);
        queue_word(add_word(3'd6, 16'd7, 8'd20, 8'd21), 1'b0);
        queue_word(add_word(3'd7, 16'h8000, 8'd21, 8'd22), 1'b0);
        queue_word(add_word(MODE_AFTER, 16'h8000, 8'd30, 8'd31), 1'b0);
        queue_word(add_word(MODE_WHILE, 16'h7fff, 8'd31, 8'd200), 1'b0);
        queue_word(op_word(CMD_TICK, 6'd0), 1'b1);
        queue_word(op_word(CMD_TICK, 6'd63), 1'b0);
        queue_word(op_word(CMD_ROUND, 6'd0), 1'b0);
        queue_word(op_word(CMD_ROUND, 6'd63), 1'b0);
        queue_word(op_word(CMD_REMOVE, 6'd0), 1'b0);
        queue_word(op_word(CMD_REMOVE, 6'd63), 1'b0);
        queue_word(add_word(MODE_PLAIN, 16'd1, 8'd40, 8'd41), 1'b0);
        queue_word(add_word(MODE_LIMITED, 16'd0, 8'd31, 8'd42), 1'b0);
        queue_word(add_word(MODE_WHILE_AFTER, 16'd1, 8'd50, 8'd60), 1'b0);
        queue_word(op_word(CMD_ROUND, 6'd0), 1'b0);
        queue_word(op_word(CMD_TICK, 6'd0), 1'b0);
        dir_n = n_queued;

        // random phases, one tick period each
        for (ph = 0; ph < 5; ph++) begin
            set_period(ph == 4 ? 10'($urandom_range(2, 999)) : periods[ph]);
            if (ph == 2) begin
                sync_sender();
                fill_table();
            end
            while (n_queued < dir_n + (ph + 1) * PHASE_ITEMS) random_sequence();
        end

        sync_sender();
        waited = 0;
        while (due_words.size() > 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LAT) @(posedge i_clk);
        if (due_words.size() > 0) begin
            $display("%0d expected result words never arrived", due_words.size());
            n_err += due_words.size();
        end

        $display("run covered %0d command words under %0d tick period settings, %0d result words",
                 n_sent, n_periods + 1, n_words);
        $display("adds placed %0d, duplicates %0d, table full %0d, sub callbacks %0d, errors %0d",
                 n_added, n_dup, n_full, n_sub, n_err);
        if (n_err == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
